// ===== hdl/two_class_priority_queue_unit_macros.svh =====
// ----------------------------------------------------------------------------
// two class priority queue assertion macros
// shared concurrent assertion forms for the queue unit
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define TWO_CLASS_PRIORITY_QUEUE_UNIT_MACROS_SVH

// same cycle implication
`define TCPQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcpq assertion failed");

// next cycle implication
`define TCPQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcpq assertion failed");

`endif

// ===== hdl/tcpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_pkg
// types and constants of the two class priority queue
// ----------------------------------------------------------------------------
package tcpq_pkg;

   localparam int CLASS_DEPTH = 16;
   localparam int ID_WIDTH    = 16;
   localparam int SEQ_WIDTH   = 16;
   localparam int COUNT_WIDTH = $clog2(CLASS_DEPTH + 1);

   localparam logic [1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [1:0] CMD_CLEAR   = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] customer_id;
      logic        is_priority;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] sequence_number;
      logic [15:0] out_customer_id;
      logic        out_priority;
   } rsp_type;

   typedef struct packed {
      logic [SEQ_WIDTH-1:0] seq;
      logic [ID_WIDTH-1:0]  id;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } chain_ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } chain_status_type;

endpackage

// ===== hdl/tcpq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_cell
// one queue slot: loads a new entry or takes its upper neighbour's entry
// ----------------------------------------------------------------------------
module tcpq_cell (
   input  logic                clock,
   input  logic                load,
   input  logic                shift,
   input  tcpq_pkg::entry_type load_data,
   input  tcpq_pkg::entry_type next_data,
   output tcpq_pkg::entry_type data
);
   import tcpq_pkg::*;

   entry_type data_ff;
   entry_type data_in;

   always_comb begin
      data_in = data_ff;
      if (load) begin
         data_in = load_data;
      end else if (shift) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== hdl/tcpq_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_chain
// one class fifo as a row of cells, head in cell zero, shifting on pop
// ----------------------------------------------------------------------------
module tcpq_chain (
   input  logic                       clock,
   input  logic                       reset,
   input  tcpq_pkg::chain_ctrl_type   ctrl,
   input  tcpq_pkg::entry_type        push_data,
   output tcpq_pkg::entry_type        head,
   output tcpq_pkg::chain_status_type status
);
   import tcpq_pkg::*;

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   entry_type              cell_data [CLASS_DEPTH];

   for (genvar i = 0; i < CLASS_DEPTH; i++) begin : g_cell
      entry_type next_data;
      logic      load;

      if (i == CLASS_DEPTH - 1) begin : g_last
         assign next_data = cell_data[i];
      end else begin : g_mid
         assign next_data = cell_data[i + 1];
      end

      assign load = ctrl.push && (count_ff == COUNT_WIDTH'(i));

      tcpq_cell u_cell (
         .clock     (clock),
         .load      (load),
         .shift     (ctrl.pop),
         .load_data (push_data),
         .next_data (next_data),
         .data      (cell_data[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.clear) begin
         count_in = '0;
      end else if (ctrl.push) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head         = cell_data[0];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == COUNT_WIDTH'(CLASS_DEPTH));

endmodule

// ===== hdl/two_class_priority_queue_unit.sv =====
// result: registered, and valid in the cycle after its transaction is accepted
// throughput: one transaction per cycle while the waiting result is not stalled
// a new transaction is taken while a result waits, unless that result is stalled
// reset: synchronous, clears both fill counts, the sequence counter and the result valid
// cell contents are not reset and are never read before being written
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_priority_queue_unit
// strict priority queue with a priority and a regular class of cell rows
// ----------------------------------------------------------------------------
`include "two_class_priority_queue_unit_macros.svh"

module two_class_priority_queue_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tcpq_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tcpq_pkg::rsp_type rsp_payload
);
   import tcpq_pkg::*;

   logic             accept;
   logic             q_empty;
   chain_ctrl_type   p_ctrl;
   chain_ctrl_type   r_ctrl;
   chain_status_type p_status;
   chain_status_type r_status;
   entry_type        p_head;
   entry_type        r_head;
   entry_type        push_data;
   logic [SEQ_WIDTH-1:0] seq_ff;
   logic [SEQ_WIDTH-1:0] seq_in;
   logic [SEQ_WIDTH-1:0] seq_next;
   rsp_type          rsp_result;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_payload_ff;
   rsp_type          rsp_payload_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign q_empty   = p_status.empty && r_status.empty;
   assign seq_next  = seq_ff + SEQ_WIDTH'(1);

   assign push_data.seq = seq_next;
   assign push_data.id  = ID_WIDTH'(req_payload.customer_id);

   always_comb begin
      p_ctrl     = '0;
      r_ctrl     = '0;
      seq_in     = seq_ff;
      rsp_result = '0;
      case (req_payload.command)
         CMD_ENQUEUE: begin
            if (req_payload.is_priority ? p_status.full : r_status.full) begin
               rsp_result.status = ST_FULL;
            end else begin
               p_ctrl.push                = accept && req_payload.is_priority;
               r_ctrl.push                = accept && !req_payload.is_priority;
               seq_in                     = seq_next;
               rsp_result.sequence_number = seq_next;
            end
         end
         CMD_DEQUEUE: begin
            if (q_empty) begin
               rsp_result.status = ST_EMPTY;
            end else if (!p_status.empty) begin
               p_ctrl.pop                 = accept;
               rsp_result.sequence_number = p_head.seq;
               rsp_result.out_customer_id = 16'(p_head.id);
               rsp_result.out_priority    = 1'b1;
            end else begin
               r_ctrl.pop                 = accept;
               rsp_result.sequence_number = r_head.seq;
               rsp_result.out_customer_id = 16'(r_head.id);
            end
         end
         CMD_CLEAR: begin
            if (q_empty) begin
               rsp_result.status = ST_EMPTY;
            end else begin
               p_ctrl.clear = accept;
               r_ctrl.clear = accept;
               seq_in       = '0;
            end
         end
         default: begin
            rsp_result.status = ST_OK;
         end
      endcase
   end

   tcpq_chain u_priority (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (p_ctrl),
      .push_data (push_data),
      .head      (p_head),
      .status    (p_status)
   );

   tcpq_chain u_regular (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (r_ctrl),
      .push_data (push_data),
      .head      (r_head),
      .status    (r_status)
   );

   assign rsp_valid_in   = accept || (rsp_valid_ff && rsp_stall);
   assign rsp_payload_in = accept ? rsp_result : rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            seq_ff <= seq_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `TCPQ_ASSERT_NXT(a_clear_empties, clock, reset,
      accept && req_payload.command == CMD_CLEAR && !q_empty,
      p_status.empty && r_status.empty && seq_ff == '0)
   `TCPQ_ASSERT_NXT(a_priority_first, clock, reset,
      accept && req_payload.command == CMD_DEQUEUE && !p_status.empty,
      rsp_payload_ff.out_priority && rsp_payload_ff.status == ST_OK)
   `TCPQ_ASSERT_IMP(a_full_no_seq, clock, reset,
      rsp_valid_ff && rsp_payload_ff.status == ST_FULL,
      rsp_payload_ff.sequence_number == '0 && !rsp_payload_ff.out_priority)

endmodule
